// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk_i outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and types of the masked byte pattern search.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

  // Sizing of the search.
  localparam int MAX_PATTERN = 16;
  localparam int MAX_ALIGN   = 64;
  localparam int OFFSET_BITS = 32;

  // Fixed field widths of the ports.
  localparam int PAT_BYTES   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int RAW_LEN_W   = 5;
  localparam int RAW_ALIGN_W = 7;
  localparam int OUT_W       = 32;

  // Derived widths.
  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int ALIGN_W   = $clog2(MAX_ALIGN + 1);
  localparam int PH_W      = (MAX_ALIGN > 1) ? $clog2(MAX_ALIGN) : 1;
  localparam int IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int AL_W      = $clog2((MAX_PATTERN + 1) * MAX_ALIGN + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_HIGH   = 3'd1,
    REG_CARE_MASK  = 3'd2,
    REG_PAT_LENGTH = 3'd3,
    REG_ALIGNMENT  = 3'd4,
    REG_REPORT_ALL = 3'd5
  } cfg_reg_e;

  // Effective configuration seen by the match core.
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pat;
    logic [PAT_BYTES-1:0]      care;
    logic [LEN_W-1:0]          len;
    logic [ALIGN_W-1:0]        align;
    logic                      report_all;
  } cfg_t;

  // Status of the match core for the item being evaluated.
  typedef struct packed {
    logic hit;
    logic done;
  } core_stat_t;

endpackage

`default_nettype wire

// File: rtl/mbps_cfg.sv
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file; length and alignment are stored already clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output mbps_pkg::cfg_t                   cfg_o
);
  import mbps_pkg::*;

  logic [63:0]          pat_lo_q;
  logic [63:0]          pat_hi_q;
  logic [PAT_BYTES-1:0] care_q;
  logic [LEN_W-1:0]     len_q;
  logic [ALIGN_W-1:0]   align_q;
  logic                 report_all_q;

  logic [RAW_LEN_W-1:0]   raw_len;
  logic [RAW_ALIGN_W-1:0] raw_align;
  logic [LEN_W-1:0]       len_d;
  logic [ALIGN_W-1:0]     align_d;

  // Clamp length and alignment to their legal ranges at write time.
  always_comb begin
    raw_len   = cfg_data_i[RAW_LEN_W-1:0];
    raw_align = cfg_data_i[RAW_ALIGN_W-1:0];
    if (raw_len == '0) begin
      len_d = LEN_W'(1);
    end else if (int'(raw_len) > MAX_PATTERN) begin
      len_d = LEN_W'(MAX_PATTERN);
    end else begin
      len_d = LEN_W'(raw_len);
    end
    if (raw_align == '0) begin
      align_d = ALIGN_W'(1);
    end else if (int'(raw_align) > MAX_ALIGN) begin
      align_d = ALIGN_W'(MAX_ALIGN);
    end else begin
      align_d = ALIGN_W'(raw_align);
    end
  end

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q     <= '0;
      pat_hi_q     <= '0;
      care_q       <= '0;
      len_q        <= LEN_W'(1);
      align_q      <= ALIGN_W'(1);
      report_all_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PAT_LOW:    pat_lo_q     <= cfg_data_i;
        REG_PAT_HIGH:   pat_hi_q     <= cfg_data_i;
        REG_CARE_MASK:  care_q       <= cfg_data_i[PAT_BYTES-1:0];
        REG_PAT_LENGTH: len_q        <= len_d;
        REG_ALIGNMENT:  align_q      <= align_d;
        REG_REPORT_ALL: report_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.pat        = {pat_hi_q, pat_lo_q};
  assign cfg_o.care       = care_q;
  assign cfg_o.len        = len_q;
  assign cfg_o.align      = align_q;
  assign cfg_o.report_all = report_all_q;

endmodule

`default_nettype wire

// File: rtl/mbps_core.sv
// ----------------------------------------------------------------------------
// mbps_core
// Scan state (byte window, offset counter, phase, spacing) and the masked
// compare of the window that ends on the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbps_pkg::cfg_t                cfg_i,
  input  logic                          step_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          region_end_i,
  output mbps_pkg::core_stat_t          stat_o,
  output logic [mbps_pkg::OUT_W-1:0]    match_offset_o
);
  import mbps_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CNT_MAX = {OFFSET_BITS{1'b1}};

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [OFFSET_BITS-1:0]    cnt_q, cnt_d;
  logic [PH_W-1:0]           ph_q, ph_d;
  logic [OFFSET_BITS-1:0]    ens_q, ens_d;
  logic                      done_q, done_d;

  logic [MAX_PATTERN-1:0][7:0] win_new;
  logic [OFFSET_BITS-1:0]      cnt_inc;
  logic [ALIGN_W-1:0]          ph_inc;
  logic [PH_W-1:0]             ph_new;
  logic [OFFSET_BITS-1:0]      start;
  logic [OFFSET_BITS:0]        next_sum;
  logic [OFFSET_BITS:0]        adv;
  logic                      not_sat;
  logic                      len_ok;
  logic                      align_ok;
  logic                      pat_ok;
  logic                      hit;

  // Window as it stands after the new byte is shifted in.
  always_comb begin
    win_new[0] = data_byte_i;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_new[i] = win_q[i-1];
    end
  end

  // Offset counter and running alignment phase.
  always_comb begin
    not_sat = (cnt_q != CNT_MAX);
    cnt_inc = cnt_q + OFFSET_BITS'(1);
    ph_inc  = ALIGN_W'(ph_q) + ALIGN_W'(1);
    if (ph_inc >= cfg_i.align) begin
      ph_new = '0;
    end else begin
      ph_new = PH_W'(ph_inc);
    end
    len_ok = (cnt_inc >= OFFSET_BITS'(cfg_i.len));
    start  = cnt_inc - OFFSET_BITS'(cfg_i.len);
  end

  // The start is aligned when phase + k * alignment equals the length for some k.
  always_comb begin
    align_ok = 1'b0;
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      if (AL_W'(ph_new) + AL_W'(k) * AL_W'(cfg_i.align) == AL_W'(cfg_i.len)) begin
        align_ok = 1'b1;
      end
    end
  end

  // Masked compare: pattern byte j lines up with window entry len - 1 - j.
  always_comb begin
    logic [IDX_W-1:0] idx;
    logic             byte_ok;
    pat_ok = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      idx     = IDX_W'(int'(cfg_i.len) - 1 - j);
      byte_ok = 1'b1;
      if (j < PAT_BYTES && j < int'(cfg_i.len)) begin
        if (cfg_i.care[IDX_W'(j)] && (win_new[idx] != cfg_i.pat[IDX_W'(j)])) begin
          byte_ok = 1'b0;
        end
      end
      pat_ok = pat_ok & byte_ok;
    end
  end

  // Hit decision and the spacing to the next allowed start.
  always_comb begin
    hit      = not_sat && len_ok && !done_q && align_ok && (start >= ens_q) && pat_ok;
    adv      = (cfg_i.align > ALIGN_W'(1)) ? (OFFSET_BITS+1)'(cfg_i.align)
                                           : (OFFSET_BITS+1)'(cfg_i.len);
    next_sum = {1'b0, start} + adv;
  end

  // Next scan state.
  always_comb begin
    win_d  = win_new[WIN_DEPTH-1:0];
    cnt_d  = cnt_q;
    ph_d   = ph_q;
    ens_d  = ens_q;
    done_d = done_q;
    if (not_sat) begin
      cnt_d = cnt_inc;
      ph_d  = ph_new;
    end
    if (hit) begin
      if (cfg_i.report_all) begin
        ens_d = next_sum[OFFSET_BITS] ? CNT_MAX : next_sum[OFFSET_BITS-1:0];
      end else begin
        done_d = 1'b1;
      end
    end
    if (region_end_i) begin
      win_d  = '0;
      cnt_d  = '0;
      ph_d   = '0;
      ens_d  = '0;
      done_d = 1'b0;
    end
  end

  // Scan state advances once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      ph_q   <= '0;
      ens_q  <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      win_q  <= win_d;
      cnt_q  <= cnt_d;
      ph_q   <= ph_d;
      ens_q  <= ens_d;
      done_q <= done_d;
    end
  end

  assign stat_o.hit     = hit;
  assign stat_o.done    = done_q;
  assign match_offset_o = OUT_W'(start);

endmodule

`default_nettype wire

// File: rtl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// Streaming search of a byte stream for a masked pattern of up to 16 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the input channel (in_valid_i, data_byte_i, region_end_i);
//   a transaction completes when in_valid_i is high and in_stall_o is low.
//   Each hit leaves on the output channel as match_offset_o, the start offset
//   of the matching window within the current region; a transaction completes
//   when out_valid_o is high and out_stall_i is low.
//   The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) writes
//   one register per transaction and is always ready. Write it only while no
//   bytes are in flight.
//   Throughput is one byte per cycle unless the receiver stalls: the input
//   register, the combinational compare against all window positions and
//   the result register overlap. Each byte is held in the input register and its hit in the result register.
//   A byte with region_end_i set ends the region; the scan state returns to
//   its reset values after that byte is evaluated.
//   When the receiver stalls with a result waiting, the input register holds
//   one more byte and then in_stall_o rises until the result is taken.
//   Reset clears the scan state and sets length 1, alignment 1, first-hit mode.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             region_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mbps_pkg::OUT_W-1:0]       match_offset_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mbps_pkg::*;

`include "assert_macros.svh"

  cfg_t       cfg;
  core_stat_t stat;

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             end_q;
  logic             out_valid_q;
  logic [OUT_W-1:0] offset_q;
  logic [OUT_W-1:0] core_offset;
  logic             adv;
  logic             step;
  logic             in_accept;

  // Handshake control.
  assign adv         = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && adv;
  assign in_stall_o  = in_valid_q && !adv;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  mbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      end_q  <= region_end_i;
    end
  end

  mbps_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .step_i         (step),
    .data_byte_i    (byte_q),
    .region_end_i   (end_q),
    .stat_o         (stat),
    .match_offset_o (core_offset)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= step && stat.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && stat.hit) begin
      offset_q <= core_offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_offset_o = offset_q;

  // A full input register behind a stalled result must hold off the sender.
  `ASSERT_IMPL(a_stall_backpressure, in_valid_q && out_valid_o && out_stall_i, in_stall_o,
               "input not stalled while result register is blocked")
  // A new result only follows a byte that was held in the input register.
  `ASSERT_IMPL(a_result_source, $rose(out_valid_o), $past(in_valid_q),
               "result appeared without a byte being processed")
  // Once a region is marked done by its first hit in first-hit mode, no further hit is raised.
  `ASSERT_IMPL(a_done_blocks_hit, stat.done, !stat.hit,
               "hit raised after region was marked done")

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Testbench for masked_byte_pattern_search
// Streams regions of bytes through the search and checks every reported
// match offset against a predictor that runs in the testbench itself. Covers
// wildcards, alignment, both report modes, clamped register values, changes
// of the settings in the middle of a region, idle and stall mixes on both
// channels, and one long hold-off of the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  // Writes to these indexes must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_BITS) - 1;
  localparam int unsigned RANDOM_BYTES   = 1250;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned SHOW_LIMIT     = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_item_t;

  // Block ports.
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i    = '0;
  logic                  region_end_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [OUT_W-1:0]      match_offset_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Copy of the registers as last written.
  logic [127:0] pat_cfg  = '0;
  logic [15:0]  care_cfg = '0;
  logic [4:0]   len_cfg  = 5'd1;
  logic [6:0]   al_cfg   = 7'd1;
  logic         all_cfg  = 1'b0;

  // Predicted scan state.
  logic [7:0]        win_q [MAX_PATTERN];
  longint unsigned   seen_cnt   = 0;
  int unsigned       start_ph   = 0;
  longint unsigned   next_start = 0;
  bit                region_hit = 1'b0;

  scan_item_t        byte_feed_q [$];
  logic [OUT_W-1:0]  hit_offsets_q [$];

  int unsigned bytes_queued    = 0;
  int unsigned bytes_taken     = 0;
  int unsigned random_bytes    = 0;
  int unsigned regions_seen    = 0;
  int unsigned hits_predicted  = 0;
  int unsigned offsets_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned settings_used   = 0;
  int unsigned fail_count      = 0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_toggle    = 1'b0;
  bit          hold_seen      = 1'b0;
  int unsigned hold_left      = 0;

  masked_byte_pattern_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .region_end_i  (region_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .match_offset_o(match_offset_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Pattern length and alignment as the block applies them after clamping.
  function automatic int unsigned window_len();
    if (len_cfg == 5'd0) return 1;
    if (int'(len_cfg) > MAX_PATTERN) return MAX_PATTERN;
    return 32'(len_cfg);
  endfunction

  function automatic int unsigned step_align();
    if (al_cfg == 7'd0) return 1;
    if (int'(al_cfg) > MAX_ALIGN) return MAX_ALIGN;
    return 32'(al_cfg);
  endfunction

  function automatic void clear_scan_state();
    foreach (win_q[i]) win_q[i] = '0;
    seen_cnt   = 0;
    start_ph   = 0;
    next_start = 0;
    region_hit = 1'b0;
  endfunction

  // Advances the predicted scan by one byte and queues the offset it reports.
  function automatic void scan_byte(input logic [7:0] b, input logic last);
    int unsigned     len_e;
    int unsigned     al_e;
    int unsigned     resid;
    longint unsigned start_off;
    longint unsigned gap;
    bit              same;
    len_e = window_len();
    al_e  = step_align();
    for (int i = MAX_PATTERN - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = b;
    if (seen_cnt < OFFSET_MAX) begin
      seen_cnt++;
      start_ph = (start_ph + 1 >= al_e) ? 0 : start_ph + 1;
      if (seen_cnt >= 64'(len_e) && !region_hit) begin
        start_off = seen_cnt - 64'(len_e);
        resid = ((start_ph % al_e) + al_e * MAX_PATTERN - len_e) % al_e;
        same = 1'b1;
        for (int j = 0; j < len_e; j++) begin
          if (care_cfg[j] && win_q[len_e-1-j] != pat_cfg[8*j +: 8]) same = 1'b0;
        end
        if (resid == 0 && start_off >= next_start && same) begin
          gap = 64'((al_e > 1) ? al_e : len_e);
          hit_offsets_q.push_back(start_off[OUT_W-1:0]);
          hits_predicted++;
          if (all_cfg) begin
            next_start = (OFFSET_MAX - start_off < gap) ? OFFSET_MAX : start_off + gap;
          end else begin
            region_hit = 1'b1;
          end
        end
      end
    end
    if (last) begin
      clear_scan_state();
      regions_seen++;
    end
  endfunction

  // Input driver: offers the next pending byte, holding it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    scan_item_t nxt;
    bit         taken;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= '0;
      region_end_i <= 1'b0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        scan_byte(data_byte_i, region_end_i);
        bytes_taken++;
      end
      if (!in_valid_i || taken) begin
        if (byte_feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = byte_feed_q.pop_front();
          in_valid_i   <= 1'b1;
          data_byte_i  <= nxt.data;
          region_end_i <= nxt.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted transaction and drives the stall.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen   <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        offsets_checked++;
        if (hit_offsets_q.size() == 0) begin
          flag_error($sformatf("expected no result, got match_offset %0d", match_offset_o));
        end else begin
          want = hit_offsets_q.pop_front();
          if (match_offset_o !== want) begin
            flag_error($sformatf("match_offset expected %0d, got %0d", want, match_offset_o));
          end
        end
      end
      // A toggle of the hold request starts a long stretch of stalling.
      if (hold_toggle != hold_seen) begin
        hold_seen   <= hold_toggle;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b, input logic last);
    scan_item_t it;
    it.data = b;
    it.last = last;
    byte_feed_q.push_back(it);
    bytes_queued++;
  endfunction

  // One register write transaction; leaves valid high for a following write.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PAT_LOW:    pat_cfg[63:0]   = val;
      REG_PAT_HIGH:   pat_cfg[127:64] = val;
      REG_CARE_MASK:  care_cfg        = val[15:0];
      REG_PAT_LENGTH: len_cfg         = val[4:0];
      REG_ALIGNMENT:  al_cfg          = val[6:0];
      REG_REPORT_ALL: all_cfg         = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Writes the selected registers; unused upper data bits carry noise.
  task automatic program_regs(input bit [7:0] sel, input logic [127:0] pat,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic [6:0] al, input bit all);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    if (sel[REG_PAT_LOW])    cfg_write(REG_PAT_LOW, pat[63:0]);
    if (sel[REG_PAT_HIGH])   cfg_write(REG_PAT_HIGH, pat[127:64]);
    if (sel[REG_CARE_MASK])  cfg_write(REG_CARE_MASK, {junk[63:16], care});
    if (sel[REG_PAT_LENGTH]) cfg_write(REG_PAT_LENGTH, {junk[63:5], len});
    if (sel[REG_ALIGNMENT])  cfg_write(REG_ALIGNMENT, {junk[63:7], al});
    if (sel[REG_REPORT_ALL]) cfg_write(REG_REPORT_ALL, {junk[63:1], all});
    if (sel[REG_SPARE_6])    cfg_write(REG_SPARE_6, ~junk);
    if (sel[REG_SPARE_7])    cfg_write(REG_SPARE_7, junk);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every byte is taken and every offset is out, then settles.
  task automatic drain_block();
    int unsigned waited;
    waited = 0;
    while (bytes_taken != bytes_queued) @(posedge clk_i);
    while (hit_offsets_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (hit_offsets_q.size() != 0) begin
      flag_error($sformatf("%0d expected offsets never arrived, oldest expected %0d, got none",
                           hit_offsets_q.size(), hit_offsets_q[0]));
      hit_offsets_q.delete();
    end
  endtask

  function automatic logic [7:0] pick_byte();
    int unsigned j;
    j = $urandom_range(0, PAT_BYTES - 1);
    if ($urandom_range(0, 1) != 0) return pat_cfg[8*j +: 8];
    return 8'($urandom_range(0, 3));
  endfunction

  // Queues one region (or part of one) with planted, sometimes broken,
  // copies of the pattern in a noise or narrow-alphabet background.
  task automatic queue_region(input int unsigned nb, input bit close_it);
    logic [7:0]  region_bytes [$];
    int unsigned len_e;
    int unsigned al_e;
    int unsigned pos;
    int unsigned j;
    bit          narrow;
    len_e  = window_len();
    al_e   = step_align();
    narrow = 1'($urandom_range(0, 1));
    for (int i = 0; i < nb; i++) begin
      region_bytes.push_back(narrow ? pick_byte() : 8'($urandom_range(0, 255)));
    end
    if (nb >= len_e && $urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 4)) begin
        pos = $urandom_range(0, nb - len_e);
        if ($urandom_range(0, 1) != 0) pos = pos - (pos % al_e);
        for (int k = 0; k < len_e; k++) begin
          if (care_cfg[k]) region_bytes[pos+k] = pat_cfg[8*k +: 8];
        end
        if ($urandom_range(0, 4) == 0) begin
          j = $urandom_range(0, len_e - 1);
          region_bytes[pos+j] = ~region_bytes[pos+j];
        end
      end
    end
    for (int i = 0; i < nb; i++) push_byte(region_bytes[i], close_it && i == nb - 1);
  endtask

  task automatic random_settings();
    logic [127:0] pat;
    logic [15:0]  care;
    logic [4:0]   len;
    logic [6:0]   al;
    bit           all;
    bit [7:0]     sel;
    int unsigned  pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(16, 31));
    else if (pick < 3) len = 5'($urandom_range(7, 16));
    else len = 5'($urandom_range(1, 6));
    pick = $urandom_range(0, 9);
    if (pick == 0) al = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(64, 127));
    else if (pick < 3) al = 7'($urandom_range(5, 16));
    else al = 7'($urandom_range(1, 4));
    pick = $urandom_range(0, 9);
    if (pick == 0) care = '0;
    else if (pick == 1) care = '1;
    else care = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) pat = '0;
    else if (pick == 1) pat = '1;
    else if (pick < 6) begin
      for (int i = 0; i < PAT_BYTES; i++) pat[8*i +: 8] = 8'($urandom_range(0, 3));
    end else pat = {$urandom, $urandom, $urandom, $urandom};
    all = 1'($urandom_range(0, 1));
    sel = 8'($urandom_range(1, 63));
    if ($urandom_range(0, 7) == 0) sel[7:6] = 2'($urandom_range(1, 3));
    program_regs(sel, pat, care, len, al, all);
  endtask

  initial begin : stimulus
    int unsigned target;
    int unsigned phase_bytes;
    int unsigned nb;
    int unsigned len_e;
    int unsigned al_e;
    clear_scan_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: length 1, all wildcards, first hit only.
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h5A, 1'b1);
    drain_block();

    // Four-byte pattern with a wildcard, alignment 2, all hits, plus
    // writes to the unused indexes. A short region first, then aligned,
    // wildcard and unaligned occurrences.
    program_regs(8'hFF, 128'h0000_0000_0000_0000_0000_0000_4433_2211, 16'h000B,
                 5'd4, 7'd2, 1'b1);
    push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b1);
    push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h44, 1'b0); push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h44, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);
    drain_block();

    // Length zero and alignment zero act as one; all wildcards, first hit.
    program_regs(8'h3C, pat_cfg, 16'h0000, 5'd0, 7'd0, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b1);
    drain_block();

    // Every byte hits while the receiver holds off, so the block backs up.
    program_regs(8'h3C, pat_cfg, 16'h0000, 5'd1, 7'd1, 1'b1);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 48; i++) push_byte(8'($urandom_range(0, 255)), i == 47);
    drain_block();

    // Random settings, each with its own idling mix; regions may run on
    // across a change of settings.
    while (random_bytes < RANDOM_BYTES) begin
      random_settings();
      send_idle_pct  <= (settings_used % 4 == 1) ? 45 : (settings_used % 4 == 3) ? 28 : 0;
      recv_stall_pct <= (settings_used % 4 == 2) ? 45 : (settings_used % 4 == 3) ? 28 : 0;
      len_e = window_len();
      al_e  = step_align();
      target = $urandom_range(20, 45);
      phase_bytes = 0;
      while (phase_bytes < target) begin
        if ($urandom_range(0, 7) == 0) nb = $urandom_range(1, 3);
        else if (al_e > 8 && $urandom_range(0, 2) == 0) nb = $urandom_range(len_e, 2 * al_e + len_e);
        else nb = $urandom_range(len_e, len_e + 24);
        queue_region(nb, $urandom_range(0, 5) != 0);
        phase_bytes += nb;
      end
      random_bytes += phase_bytes;
      drain_block();
      settings_used++;
    end

    $display("Scanned %0d bytes in %0d closed regions under %0d random settings, %0d writes.",
             bytes_taken, regions_seen, settings_used, cfg_writes);
    $display("Predicted %0d match offsets and checked %0d results from the block.",
             hits_predicted, offsets_checked);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors found.", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hang anywhere in the run.
  initial begin : watchdog
    #3_000_000;
    $display("Timeout with %0d of %0d bytes taken.", bytes_taken, bytes_queued);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
